// ===== src/rqu_pkg.sv =====
// Shared types and constants for the retire queue unit.
// Used by rqu_ctrl, rqu_dpath and retire_queue_unit; depends on nothing.
package rqu_pkg;

    localparam int QUEUE_SLOTS_DEF = 64;

    localparam int MODE_W   = 2;
    localparam int IDX_W    = 16;
    localparam int MOPS_W   = 8;
    localparam int TOKEN_W  = 6;
    localparam int STATUS_W = 3;
    localparam int LIMIT_W  = 7;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_RESERVE = 2'd0,
        MODE_EXECUTE = 2'd1,
        MODE_TICK    = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_RESERVED     = 3'd0,
        STAT_NO_ROOM      = 3'd1,
        STAT_MARKED       = 3'd2,
        STAT_BAD_TOKEN    = 3'd3,
        STAT_RETIRED      = 3'd4,
        STAT_NONE_RETIRED = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RT_CHECK,
        ST_RT_READ
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic reserve;
        logic execute;
        logic tick_start;
        logic rt_continue;
        logic rt_stop;
        logic rt_retire;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rt_go;
    } t_stat;

endpackage

// ===== src/rqu_dpath.sv =====
// Datapath of the retire queue unit: slot memory, occupancy flags, pointers
// and the registered result port. Depends on rqu_pkg.
module rqu_dpath #(
    parameter int QUEUE_SLOTS = rqu_pkg::QUEUE_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rqu_pkg::t_cmd                 i_cmd,
    output rqu_pkg::t_stat                o_stat,
    input  logic [rqu_pkg::IDX_W-1:0]     i_instr_index,
    input  logic [rqu_pkg::MOPS_W-1:0]    i_micro_ops,
    input  logic [rqu_pkg::TOKEN_W-1:0]   i_token,
    input  logic [rqu_pkg::LIMIT_W-1:0]   i_retire_limit,
    output logic                          o_valid,
    output rqu_pkg::t_status              o_status,
    output logic [rqu_pkg::TOKEN_W-1:0]   o_token_out,
    output logic [rqu_pkg::IDX_W-1:0]     o_retired_index,
    output logic                          o_last
);
    import rqu_pkg::*;

    localparam int PW      = $clog2(QUEUE_SLOTS);
    localparam int CW      = $clog2(QUEUE_SLOTS + 1);
    localparam int SW      = CW + 1;
    localparam int ENTRY_W = IDX_W + CW;

    // Slot memory: instruction index and span of each entry, by head slot.
    logic [ENTRY_W-1:0]     r_mem [QUEUE_SLOTS];
    logic [ENTRY_W-1:0]     r_rd_data;

    logic [PW-1:0]          r_alloc_ptr;
    logic [PW-1:0]          r_retire_ptr;
    logic [CW-1:0]          r_free;
    logic [QUEUE_SLOTS-1:0] r_reserved;
    logic [QUEUE_SLOTS-1:0] r_executed;
    logic [CW-1:0]          r_count;
    logic                   r_pend_valid;
    logic [IDX_W-1:0]       r_pend_idx;

    logic                   r_out_valid;
    t_status                r_out_status;
    logic [TOKEN_W-1:0]     r_out_token;
    logic [IDX_W-1:0]       r_out_index;
    logic                   r_out_last;

    logic [CW-1:0]          n_span;
    logic                   no_room;
    logic [SW-1:0]          alloc_sum;
    logic [PW-1:0]          n_alloc_ptr;
    logic [PW-1:0]          tok_slot;
    logic                   tok_ok;
    logic [CW-1:0]          rd_span;
    logic [IDX_W-1:0]       rd_idx;
    logic [CW-1:0]          ret_span;
    logic [SW-1:0]          ret_sum;
    logic [PW-1:0]          n_retire_ptr;
    logic [SW-1:0]          free_sum;
    logic [CW-1:0]          n_free_ret;
    logic                   limit_hit;
    logic                   count_full;

    always_comb begin
        // Requested micro-op count clamped to one through the queue size.
        if (i_micro_ops == '0) begin
            n_span = CW'(1);
        end else if (int'(i_micro_ops) > QUEUE_SLOTS) begin
            n_span = CW'(QUEUE_SLOTS);
        end else begin
            n_span = CW'(i_micro_ops);
        end
        no_room   = (r_free < n_span);
        alloc_sum = SW'(r_alloc_ptr) + SW'(n_span);
        if (alloc_sum >= SW'(QUEUE_SLOTS)) begin
            n_alloc_ptr = PW'(alloc_sum - SW'(QUEUE_SLOTS));
        end else begin
            n_alloc_ptr = PW'(alloc_sum);
        end

        tok_slot = i_token[PW-1:0];
        tok_ok   = (int'(i_token) < QUEUE_SLOTS) && r_reserved[tok_slot];

        rd_span  = r_rd_data[CW-1:0];
        rd_idx   = r_rd_data[ENTRY_W-1:CW];
        ret_span = (rd_span == '0) ? CW'(1) : rd_span;
        ret_sum  = SW'(r_retire_ptr) + SW'(ret_span);
        if (ret_sum >= SW'(QUEUE_SLOTS)) begin
            n_retire_ptr = PW'(ret_sum - SW'(QUEUE_SLOTS));
        end else begin
            n_retire_ptr = PW'(ret_sum);
        end
        free_sum = SW'(r_free) + SW'(ret_span);
        if (free_sum > SW'(QUEUE_SLOTS)) begin
            n_free_ret = CW'(QUEUE_SLOTS);
        end else begin
            n_free_ret = CW'(free_sum);
        end

        limit_hit  = (i_retire_limit != '0) && (LIMIT_W'(r_count) == i_retire_limit);
        count_full = (int'(r_count) >= QUEUE_SLOTS);
        o_stat.rt_go = (int'(r_free) < QUEUE_SLOTS) && !limit_hit && !count_full
                       && r_reserved[r_retire_ptr] && r_executed[r_retire_ptr];
    end

    // Memory: one write port at the allocation pointer, one registered read
    // port at the retire pointer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.reserve && !no_room) begin
            r_mem[r_alloc_ptr] <= {i_instr_index, n_span};
        end
        r_rd_data <= r_mem[r_retire_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc_ptr  <= '0;
            r_retire_ptr <= '0;
            r_free       <= CW'(QUEUE_SLOTS);
            r_reserved   <= '0;
            r_executed   <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;

            if (i_cmd.reserve) begin
                r_out_valid <= 1'b1;
                r_out_last  <= 1'b1;
                r_out_index <= '0;
                if (no_room) begin
                    r_out_status <= STAT_NO_ROOM;
                    r_out_token  <= '0;
                end else begin
                    r_out_status              <= STAT_RESERVED;
                    r_out_token               <= TOKEN_W'(r_alloc_ptr);
                    r_reserved[r_alloc_ptr]   <= 1'b1;
                    r_executed[r_alloc_ptr]   <= 1'b0;
                    r_alloc_ptr               <= n_alloc_ptr;
                    r_free                    <= r_free - n_span;
                end
            end

            if (i_cmd.execute) begin
                r_out_valid <= 1'b1;
                r_out_last  <= 1'b1;
                r_out_token <= '0;
                r_out_index <= '0;
                if (tok_ok) begin
                    r_out_status         <= STAT_MARKED;
                    r_executed[tok_slot] <= 1'b1;
                end else begin
                    r_out_status <= STAT_BAD_TOKEN;
                end
            end

            if (i_cmd.tick_start) begin
                r_count      <= '0;
                r_pend_valid <= 1'b0;
            end

            // A retired entry is held back until it is known whether another
            // follows, so that the final one carries the last flag.
            if (i_cmd.rt_continue && r_pend_valid) begin
                r_out_valid  <= 1'b1;
                r_out_last   <= 1'b0;
                r_out_status <= STAT_RETIRED;
                r_out_token  <= '0;
                r_out_index  <= r_pend_idx;
            end

            if (i_cmd.rt_stop) begin
                r_out_valid <= 1'b1;
                r_out_last  <= 1'b1;
                r_out_token <= '0;
                if (r_pend_valid) begin
                    r_out_status <= STAT_RETIRED;
                    r_out_index  <= r_pend_idx;
                end else begin
                    r_out_status <= STAT_NONE_RETIRED;
                    r_out_index  <= '0;
                end
            end

            if (i_cmd.rt_retire) begin
                r_reserved[r_retire_ptr] <= 1'b0;
                r_executed[r_retire_ptr] <= 1'b0;
                r_retire_ptr             <= n_retire_ptr;
                r_free                   <= n_free_ret;
                r_count                  <= r_count + CW'(1);
                r_pend_valid             <= 1'b1;
                r_pend_idx               <= rd_idx;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_token_out     = r_out_token;
    assign o_retired_index = r_out_index;
    assign o_last          = r_out_last;

endmodule

// ===== src/rqu_ctrl.sv =====
// Controller of the retire queue unit: decodes accepted items and walks the
// retirement loop of a tick. Depends on rqu_pkg.
module rqu_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rqu_pkg::MODE_W-1:0]   i_mode,
    input  rqu_pkg::t_stat               i_stat,
    output rqu_pkg::t_cmd                o_cmd,
    output logic                         o_busy
);
    import rqu_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    case (t_mode'(i_mode))
                        MODE_RESERVE: o_cmd.reserve = 1'b1;
                        MODE_EXECUTE: o_cmd.execute = 1'b1;
                        MODE_TICK: begin
                            o_cmd.tick_start = 1'b1;
                            n_state          = ST_RT_CHECK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RT_CHECK: begin
                if (i_stat.rt_go) begin
                    o_cmd.rt_continue = 1'b1;
                    n_state           = ST_RT_READ;
                end else begin
                    o_cmd.rt_stop = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_RT_READ: begin
                o_cmd.rt_retire = 1'b1;
                n_state         = ST_RT_CHECK;
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== src/retire_queue_unit.sv =====
// Top level of the retire queue unit: configuration register, controller
// and datapath. Depends on rqu_pkg, rqu_ctrl and rqu_dpath.
//
// Usage. An item is transferred at a rising edge where i_start is high and
// o_busy is low; i_mode selects a reservation, an execute mark or a tick.
// Results leave on o_status, o_token_out, o_retired_index and o_last, each
// valid for exactly one cycle while o_valid is high; the receiver cannot
// stall them, so the block never waits on the output side.
// Flow. A reservation or an execute mark yields its single result in the
// cycle after the transfer and leaves the block ready at once: one item per
// cycle. During a tick each retirement passes through a check state, which
// tests the head flags while the slot memory read is registered, and a read
// state, which uses the registered read data. Results of a tick leave one by
// one, the last one as o_busy falls.
// Mode three is accepted and ignored without a result.
// Configuration. One register, retire_limit, selected by every address on the APB
// port; pready is tied high and writes are expected only while idle.
// Reset. i_rst_n is synchronous; it empties the queue, clears both pointers,
// sets the free count to the queue size and the retire limit to zero. The
// slot memory is not cleared; only data of slots already reserved is ever used.
module retire_queue_unit #(
    parameter int QUEUE_SLOTS = rqu_pkg::QUEUE_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [rqu_pkg::MODE_W-1:0]    i_mode,
    input  logic [rqu_pkg::IDX_W-1:0]     i_instr_index,
    input  logic [rqu_pkg::MOPS_W-1:0]    i_micro_ops,
    input  logic [rqu_pkg::TOKEN_W-1:0]   i_token,
    output logic                          o_valid,
    output logic [rqu_pkg::STATUS_W-1:0]  o_status,
    output logic [rqu_pkg::TOKEN_W-1:0]   o_token_out,
    output logic [rqu_pkg::IDX_W-1:0]     o_retired_index,
    output logic                          o_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rqu_pkg::APB_AW-1:0]    paddr,
    input  logic [rqu_pkg::APB_DW-1:0]    pwdata,
    output logic [rqu_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import rqu_pkg::*;

    logic [LIMIT_W-1:0] r_retire_limit;
    t_cmd               cmd;
    t_stat              stat;
    t_status            status;

    // With a single register every address in the decoded range selects it.
    assign pready = 1'b1;
    assign prdata = APB_DW'(r_retire_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retire_limit <= '0;
        end else if (psel && penable && pwrite && pready) begin
            r_retire_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    rqu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_mode  (i_mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    rqu_dpath #(
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_instr_index   (i_instr_index),
        .i_micro_ops     (i_micro_ops),
        .i_token         (i_token),
        .i_retire_limit  (r_retire_limit),
        .o_valid         (o_valid),
        .o_status        (status),
        .o_token_out     (o_token_out),
        .o_retired_index (o_retired_index),
        .o_last          (o_last)
    );

    assign o_status = status;

    // A final result coincides with the block being free again; any earlier
    // result of a tick is shown while the tick is still in progress.
    a_last_vs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last != o_busy))
        else $error("last flag and busy disagree");

    // Reservations and execute marks answer with one final result next cycle.
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_mode == MODE_RESERVE || i_mode == MODE_EXECUTE))
        |=> (o_valid && o_last))
        else $error("single-result item did not answer in one cycle");

    // Only retirements can be followed by further results of the same item.
    a_nonlast_retired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (o_status == STAT_RETIRED))
        else $error("non-final result is not a retirement");

endmodule

// ===== verif/retire_queue_unit_tb.sv =====
// Self-checking testbench for retire_queue_unit: reserve, execute and tick
// commands are driven, every result is predicted and checked as it leaves.
// Depends on rqu_pkg and the retire_queue_unit RTL only.
module retire_queue_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rqu_pkg::*;

    localparam int SLOTS = QUEUE_SLOTS_DEF;

    // Mode three is not a member of t_mode; the block accepts it and stays quiet.
    localparam logic [MODE_W-1:0] MODE_UNUSED      = 2'd3;
    localparam logic [APB_AW-1:0] REG_RETIRE_LIMIT = 2'd0;

    // A tick holds o_busy high while it retires entries, but its results keep
    // leaving meanwhile, so transfers never pause for long.
    // The watchdog only has to outlast sender pauses and the drain below.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        t_status             status;
        logic [TOKEN_W-1:0]  token;
        logic [IDX_W-1:0]    index;
        logic                last;
    } t_outcome;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic [MODE_W-1:0]    i_mode;
    logic [IDX_W-1:0]     i_instr_index;
    logic [MOPS_W-1:0]    i_micro_ops;
    logic [TOKEN_W-1:0]   i_token;
    logic                 o_valid;
    logic [STATUS_W-1:0]  o_status;
    logic [TOKEN_W-1:0]   o_token_out;
    logic [IDX_W-1:0]     o_retired_index;
    logic                 o_last;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    retire_queue_unit #(.QUEUE_SLOTS(SLOTS)) DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the queue, kept in step with every accepted transfer.
    logic [IDX_W-1:0]    shadow_index [SLOTS];
    int                  shadow_span [SLOTS];
    bit                  shadow_reserved [SLOTS];
    bit                  shadow_executed [SLOTS];
    int                  alloc_ptr;
    int                  retire_ptr;
    int                  free_slots;
    logic [LIMIT_W-1:0]  retire_limit;

    // Results still owed by the block, oldest first.
    t_outcome outcomes_due[$];

    int fault_count      = 0;
    int results_seen     = 0;
    int retirements_seen = 0;
    int mode_count [4];
    int limit_settings;
    int quiet_cycles     = 0;

    function automatic t_outcome make_outcome(t_status status, logic [TOKEN_W-1:0] token,
                                              logic [IDX_W-1:0] index, logic last);
        t_outcome res;
        res.status = status;
        res.token  = token;
        res.index  = index;
        res.last   = last;
        return res;
    endfunction

    // Appends a result to the tail of the owed list.
    function automatic void owe_result(t_outcome res);
        outcomes_due.insert(outcomes_due.size(), res);
    endfunction

    function automatic void log_fault(string what);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("%s", what);
    endfunction

    function automatic void clear_shadow();
        for (int s = 0; s < SLOTS; s++) begin
            shadow_index[s]    = '0;
            shadow_span[s]     = 0;
            shadow_reserved[s] = 1'b0;
            shadow_executed[s] = 1'b0;
        end
        alloc_ptr    = 0;
        retire_ptr   = 0;
        free_slots   = SLOTS;
        retire_limit = '0;
    endfunction

    // Works out the results of one accepted command and advances the shadow.
    function automatic void predict_outcomes(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] idx,
                                             logic [MOPS_W-1:0] mops, logic [TOKEN_W-1:0] tok);
        t_outcome held;
        bit       have_held;
        int       need;
        int       head;
        int       span;
        int       count;
        case (mode)
            MODE_RESERVE: begin
                need = (mops > SLOTS) ? SLOTS : int'(mops);
                if (need < 1)
                    need = 1;
                if (free_slots < need) begin
                    owe_result(make_outcome(STAT_NO_ROOM, '0, '0, 1'b1));
                end else begin
                    head = alloc_ptr;
                    shadow_index[head]    = idx;
                    shadow_span[head]     = need;
                    shadow_reserved[head] = 1'b1;
                    shadow_executed[head] = 1'b0;
                    alloc_ptr  = (head + need) % SLOTS;
                    free_slots = free_slots - need;
                    owe_result(make_outcome(STAT_RESERVED, TOKEN_W'(head), '0, 1'b1));
                end
            end
            MODE_EXECUTE: begin
                if (int'(tok) >= SLOTS || !shadow_reserved[tok]) begin
                    owe_result(make_outcome(STAT_BAD_TOKEN, '0, '0, 1'b1));
                end else begin
                    shadow_executed[tok] = 1'b1;
                    owe_result(make_outcome(STAT_MARKED, '0, '0, 1'b1));
                end
            end
            MODE_TICK: begin
                count     = 0;
                have_held = 1'b0;
                // Each retirement is held back one step so that the final one
                // can carry the last flag.
                while (free_slots < SLOTS) begin
                    head = retire_ptr;
                    if (retire_limit != 0 && count == int'(retire_limit))
                        break;
                    if (count >= SLOTS)
                        break;
                    if (!shadow_reserved[head] || !shadow_executed[head])
                        break;
                    span = (shadow_span[head] < 1) ? 1 : shadow_span[head];
                    if (have_held)
                        owe_result(held);
                    held      = make_outcome(STAT_RETIRED, '0, shadow_index[head], 1'b0);
                    have_held = 1'b1;
                    count++;
                    shadow_reserved[head] = 1'b0;
                    shadow_executed[head] = 1'b0;
                    retire_ptr = (head + span) % SLOTS;
                    free_slots = (free_slots + span > SLOTS) ? SLOTS : free_slots + span;
                end
                if (have_held) begin
                    held.last = 1'b1;
                    owe_result(held);
                end else begin
                    owe_result(make_outcome(STAT_NONE_RETIRED, '0, '0, 1'b1));
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Picks the head of a live entry, preferring one not yet executed, so that
    // most execute commands move the queue forward.
    function automatic logic [TOKEN_W-1:0] pick_live_token();
        int live[$];
        int fresh[$];
        for (int s = 0; s < SLOTS; s++) begin
            if (shadow_reserved[s]) begin
                live.insert(live.size(), s);
                if (!shadow_executed[s])
                    fresh.insert(fresh.size(), s);
            end
        end
        if (fresh.size() != 0 && $urandom_range(3) != 0)
            return TOKEN_W'(fresh[$urandom_range(fresh.size() - 1)]);
        if (live.size() != 0)
            return TOKEN_W'(live[$urandom_range(live.size() - 1)]);
        return TOKEN_W'($urandom_range(SLOTS - 1));
    endfunction

    // One command transfer. The start line is left high afterwards, so a
    // command that follows at once keeps it high without a glitch.
    task automatic send_item(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] idx,
                             logic [MOPS_W-1:0] mops, logic [TOKEN_W-1:0] tok);
        @(negedge i_clk);
        i_start       = 1'b1;
        i_mode        = mode;
        i_instr_index = idx;
        i_micro_ops   = mops;
        i_token       = tok;
        do @(posedge i_clk); while (o_busy);
        predict_outcomes(mode, idx, mops, tok);
        mode_count[mode]++;
    endtask

    // The sender holds off now and then, one cycle at a time, and after each pause
    // holds off once more with a chance of 38 in a hundred.
    task automatic maybe_pause(bit pausing);
        if (pausing) begin
            while ($urandom_range(99) < 38) begin
                @(negedge i_clk);
                i_start = 1'b0;
            end
        end
    endtask

    // Waits until every owed result has left and the block has gone quiet.
    // Mode three commands leave nothing to wait for, hence the extra cycles.
    task automatic settle_idle();
        @(negedge i_clk);
        i_start = 1'b0;
        while (outcomes_due.size() != 0 || o_busy)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Writes the retire limit over APB while the block is idle, then reads it
    // back.
    task automatic set_retire_limit(logic [LIMIT_W-1:0] value);
        logic [APB_DW-1:0] readback;
        settle_idle();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = REG_RETIRE_LIMIT;
        pwdata  = APB_DW'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        retire_limit = value;
        limit_settings++;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (readback !== APB_DW'(value))
            log_fault($sformatf("retire limit readback: expected %0d, got %0d", value, readback));
    endtask

    // A tick on an empty queue and an execute of a slot nobody reserved.
    task automatic test_empty_queue();
        send_item(MODE_TICK, '0, '0, '0);
        send_item(MODE_EXECUTE, '0, '0, '0);
    endtask

    // A zero count is taken as one slot, counts above the queue size as the
    // whole queue; a request larger than the free space is refused.
    task automatic test_reserve_clamping();
        send_item(MODE_RESERVE, 16'hFFFF, 8'd0, 6'h3F);
        send_item(MODE_RESERVE, 16'h0000, 8'hFF, '0);
        send_item(MODE_RESERVE, 16'h1234, 8'd63, '0);
        send_item(MODE_RESERVE, 16'h5A5A, 8'd1, '0);
    endtask

    // Stalled ticks, a repeated mark, a token that lies inside an entry but
    // is not its head, an in-order retirement of two entries, an ignored mode
    // three command and a reservation of the whole queue.
    task automatic test_execute_and_retire();
        send_item(MODE_TICK, '0, '0, '0);
        send_item(MODE_EXECUTE, '0, '0, 6'd1);
        send_item(MODE_EXECUTE, '0, '0, 6'd1);
        send_item(MODE_TICK, '0, '0, '0);
        send_item(MODE_EXECUTE, '0, '0, 6'd63);
        send_item(MODE_EXECUTE, '0, '0, 6'd0);
        send_item(MODE_TICK, '0, '0, '0);
        send_item(MODE_UNUSED, 16'hFFFF, 8'hFF, 6'h3F);
        send_item(MODE_RESERVE, 16'hA5A5, 8'd64, '0);
        send_item(MODE_EXECUTE, '0, '0, 6'd0);
        send_item(MODE_TICK, '0, '0, '0);
    endtask

    // With a limit of one, two ready entries need two ticks.
    task automatic test_retire_limit();
        set_retire_limit(7'd1);
        send_item(MODE_RESERVE, 16'h0001, 8'd2, '0);
        send_item(MODE_RESERVE, 16'h0002, 8'd2, '0);
        send_item(MODE_EXECUTE, '0, '0, 6'd0);
        send_item(MODE_EXECUTE, '0, '0, 6'd2);
        send_item(MODE_TICK, '0, '0, '0);
        send_item(MODE_TICK, '0, '0, '0);
    endtask

    // Random traffic under one limit: mostly small reservations and execute
    // marks of live entries, so the queue fills and drains, with some wild
    // counts, stray tokens and mode three noise mixed in.
    task automatic test_random_traffic(logic [LIMIT_W-1:0] limit, int items, bit pausing);
        int                  pick;
        logic [MOPS_W-1:0]   mops;
        logic [TOKEN_W-1:0]  tok;
        set_retire_limit(limit);
        for (int n = 0; n < items; n++) begin
            maybe_pause(pausing);
            pick = $urandom_range(99);
            if (pick < 40) begin
                pick = $urandom_range(99);
                if (pick < 75)
                    mops = MOPS_W'($urandom_range(1, 6));
                else if (pick < 85)
                    mops = '0;
                else
                    mops = MOPS_W'($urandom_range(255));
                send_item(MODE_RESERVE, IDX_W'($urandom), mops, TOKEN_W'($urandom));
            end else if (pick < 70) begin
                tok = ($urandom_range(99) < 80) ? pick_live_token()
                                                : TOKEN_W'($urandom_range(SLOTS - 1));
                send_item(MODE_EXECUTE, IDX_W'($urandom), MOPS_W'($urandom), tok);
            end else if (pick < 97) begin
                send_item(MODE_TICK, IDX_W'($urandom), MOPS_W'($urandom), TOKEN_W'($urandom));
            end else begin
                send_item(MODE_UNUSED, IDX_W'($urandom), MOPS_W'($urandom), TOKEN_W'($urandom));
            end
        end
    endtask

    // Results cannot be held off, so each one is taken at the edge that
    // ends its strobe cycle and compared with the oldest owed result.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            results_seen++;
            if (o_status == STAT_RETIRED)
                retirements_seen++;
            if (outcomes_due.size() == 0) begin
                log_fault($sformatf({"result with nothing owed: status %0d token %0d ",
                                     "index %h last %0d"},
                                    o_status, o_token_out, o_retired_index, o_last));
            end else begin
                want = outcomes_due.pop_front();
                if (o_status !== want.status || o_token_out !== want.token ||
                    o_retired_index !== want.index || o_last !== want.last)
                    log_fault($sformatf({"result mismatch: expected status %0d token %0d ",
                                         "index %h last %0d, got status %0d token %0d ",
                                         "index %h last %0d"},
                                        want.status, want.token, want.index, want.last,
                                        o_status, o_token_out, o_retired_index, o_last));
            end
        end
    end

    // Counts cycles without any transfer on the command, result or APB side.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_mode        = MODE_TICK;
        i_instr_index = '0;
        i_micro_ops   = '0;
        i_token       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        limit_settings = 0;
        for (int m = 0; m < 4; m++)
            mode_count[m] = 0;
        clear_shadow();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_queue();
        test_reserve_clamping();
        test_execute_and_retire();
        test_retire_limit();

        // The third phase runs without any sender pauses.
        test_random_traffic(7'd0, 30, 1'b1);
        test_random_traffic(7'd1, 25, 1'b1);
        test_random_traffic(7'd64, 30, 1'b0);
        test_random_traffic(7'd2, 25, 1'b1);
        test_random_traffic(7'd63, 20, 1'b1);
        test_random_traffic(LIMIT_W'($urandom_range(64)), 27, 1'b1);

        settle_idle();

        $display({"Sent %0d reserve, %0d execute, %0d tick and %0d mode three commands ",
                  "over %0d limit settings."},
                 mode_count[MODE_RESERVE], mode_count[MODE_EXECUTE], mode_count[MODE_TICK],
                 mode_count[MODE_UNUSED], limit_settings);
        $display("Checked %0d results, %0d of them retirements, with %0d faults.",
                 results_seen, retirements_seen, fault_count);
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
